// ----- hdl/ppm_p6_pkg.sv -----
// Package: request types, codes and character constants for the P6 stream parser.
package ppm_p6_pkg;

  // One input request: a file byte or an end-of-file mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_req_t;

  // One result request.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sample;
    logic        last;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic        wide_samples;
    logic [1:0]  error_code;
  } out_req_t;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_BAD_MAGIC    = 2'd0;
  localparam logic [1:0] ERR_BAD_NUMBER   = 2'd1;
  localparam logic [1:0] ERR_SHORT_HEADER = 2'd2;
  localparam logic [1:0] ERR_SHORT_PIXELS = 2'd3;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_MAGIC  = 2'd0,
    PH_HEADER = 2'd1,
    PH_PIXELS = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  // Progress through the magic token.
  typedef enum logic [1:0] {
    MG_NONE     = 2'd0,
    MG_SAW_P    = 2'd1,
    MG_SAW_P6   = 2'd2,
    MG_MISMATCH = 2'd3
  } magic_t;

  // Header number being parsed.
  typedef enum logic [1:0] {
    HF_WIDTH  = 2'd0,
    HF_HEIGHT = 2'd1,
    HF_MAXVAL = 2'd2
  } field_t;

  // Number accumulator; the saturation value also marks a non-digit.
  localparam int unsigned ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_SAT = 17'h1FFFF;
  localparam logic [ACC_W-1:0] MAXVAL_LIMIT = 17'd65535;
  localparam logic [ACC_W-1:0] NARROW_MAXVAL = 17'd255;

  // Characters.
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;

endpackage

// ----- hdl/ppm_p6_stream_parser.sv -----
// Top level: byte-stream parser for binary PPM (P6) headers and pixel data.
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; a waiting result that is not taken holds off the input,
// and a new byte is taken in the same cycle as the waiting result leaves.
// The image size product goes through one registered multiplier that settles between
// the height token and the end of the maxval token.
// Reset (synchronous, rst_n low): parser awaits the magic token, output register empty.
module ppm_p6_stream_parser #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppm_p6_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ppm_p6_pkg::out_req_t out_data
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned PROD_W = 2 * DIM_W;
  localparam int unsigned SL_W = PROD_W + 2;
  localparam int unsigned ACC_W = ppm_p6_pkg::ACC_W;
  localparam logic [ACC_W-1:0] DIM_LIMIT = ACC_W'(MAX_DIM);

  // State registers.
  ppm_p6_pkg::phase_t phase_r, phase_nxt;
  ppm_p6_pkg::magic_t magic_r, magic_nxt;
  ppm_p6_pkg::field_t field_r, field_nxt;
  logic               in_comment_r, in_comment_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               digits_seen_r, digits_seen_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic               wide_r, wide_nxt;
  logic [SL_W-1:0]    samples_left_r, samples_left_nxt;
  logic               byte_in_pair_r, byte_in_pair_nxt;
  logic [PROD_W-1:0]  prod_r;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  ppm_p6_pkg::out_req_t out_data_r, out_data_nxt;

  logic             in_fire;
  logic [7:0]       b;
  logic             is_ws;
  logic             is_digit;
  logic [20:0]      acc_x10;
  logic [ACC_W-1:0] acc_fed;
  logic [ACC_W-1:0] limit;
  logic             number_ok;
  logic [SL_W-1:0]  samples_total;
  logic [SL_W-1:0]  samples_dec;
  logic [31:0]      width_ext;
  logic [31:0]      height_ext;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Byte classification.
  assign b        = in_data.data_byte;
  assign is_ws    = (b == ppm_p6_pkg::CH_SP) ||
                    ((b >= ppm_p6_pkg::CH_TAB) && (b <= ppm_p6_pkg::CH_CR));
  assign is_digit = (b >= ppm_p6_pkg::CH_0) && (b <= ppm_p6_pkg::CH_9);

  // Saturating decimal accumulate of one digit.
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 21'(b - ppm_p6_pkg::CH_0);
  always_comb begin
    if (!is_digit) begin
      acc_fed = ppm_p6_pkg::ACC_SAT;
    end else if (acc_r == ppm_p6_pkg::ACC_SAT) begin
      acc_fed = acc_r;
    end else if (acc_x10 > 21'(ppm_p6_pkg::ACC_SAT)) begin
      acc_fed = ppm_p6_pkg::ACC_SAT;
    end else begin
      acc_fed = acc_x10[ACC_W-1:0];
    end
  end

  // Range check of the finished number.
  assign limit     = (field_r == ppm_p6_pkg::HF_MAXVAL) ? ppm_p6_pkg::MAXVAL_LIMIT : DIM_LIMIT;
  assign number_ok = (acc_r != '0) && (acc_r <= limit);

  // Sample count: the product register settles before maxval can end.
  assign samples_total = {1'b0, prod_r, 1'b0} + {2'b00, prod_r};
  assign samples_dec   = (samples_left_r != '0) ? samples_left_r - SL_W'(1) : samples_left_r;

  assign width_ext  = 32'(width_r);
  assign height_ext = 32'(height_r);

  // Next state and result.
  always_comb begin
    phase_nxt        = phase_r;
    magic_nxt        = magic_r;
    field_nxt        = field_r;
    in_comment_nxt   = in_comment_r;
    acc_nxt          = acc_r;
    digits_seen_nxt  = digits_seen_r;
    width_nxt        = width_r;
    height_nxt       = height_r;
    wide_nxt         = wide_r;
    samples_left_nxt = samples_left_r;
    byte_in_pair_nxt = byte_in_pair_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;

    if (in_fire) begin
      out_data_nxt = '0;
      if (in_data.end_of_file) begin
        // End of file: report what is missing, then start over.
        out_data_nxt.kind = ppm_p6_pkg::KIND_ERROR;
        out_valid_nxt     = 1'b1;
        case (phase_r)
          ppm_p6_pkg::PH_MAGIC: begin
            out_data_nxt.error_code = (digits_seen_r && magic_r != ppm_p6_pkg::MG_SAW_P6) ?
                                      ppm_p6_pkg::ERR_BAD_MAGIC : ppm_p6_pkg::ERR_SHORT_HEADER;
          end
          ppm_p6_pkg::PH_HEADER: begin
            if (digits_seen_r && !number_ok) begin
              out_data_nxt.error_code = ppm_p6_pkg::ERR_BAD_NUMBER;
            end else if (digits_seen_r && field_r == ppm_p6_pkg::HF_MAXVAL) begin
              out_data_nxt.error_code = ppm_p6_pkg::ERR_SHORT_PIXELS;
            end else begin
              out_data_nxt.error_code = ppm_p6_pkg::ERR_SHORT_HEADER;
            end
          end
          ppm_p6_pkg::PH_PIXELS: begin
            out_data_nxt.error_code = ppm_p6_pkg::ERR_SHORT_PIXELS;
            out_valid_nxt = (samples_left_r != '0) || byte_in_pair_r;
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
        phase_nxt        = ppm_p6_pkg::PH_MAGIC;
        magic_nxt        = ppm_p6_pkg::MG_NONE;
        field_nxt        = ppm_p6_pkg::HF_WIDTH;
        in_comment_nxt   = 1'b0;
        acc_nxt          = '0;
        digits_seen_nxt  = 1'b0;
        width_nxt        = '0;
        height_nxt       = '0;
        wide_nxt         = 1'b0;
        samples_left_nxt = '0;
        byte_in_pair_nxt = 1'b0;
      end else if (phase_r == ppm_p6_pkg::PH_IDLE) begin
        out_valid_nxt = 1'b0;
      end else if (phase_r == ppm_p6_pkg::PH_PIXELS) begin
        // Pixel data: pass samples, drop the low byte of wide pairs.
        if (wide_r && byte_in_pair_r) begin
          out_valid_nxt    = 1'b0;
          byte_in_pair_nxt = 1'b0;
          if (samples_left_r == '0) begin
            phase_nxt = ppm_p6_pkg::PH_IDLE;
          end
        end else begin
          samples_left_nxt = samples_dec;
          if (wide_r) begin
            byte_in_pair_nxt = 1'b1;
          end else if (samples_dec == '0) begin
            phase_nxt = ppm_p6_pkg::PH_IDLE;
          end
          out_valid_nxt       = 1'b1;
          out_data_nxt.kind   = ppm_p6_pkg::KIND_PIXEL;
          out_data_nxt.sample = b;
          out_data_nxt.last   = (samples_dec == '0);
        end
      end else if (in_comment_r) begin
        // Comment runs up to and including the line feed.
        out_valid_nxt = 1'b0;
        if (b == ppm_p6_pkg::CH_LF) begin
          in_comment_nxt = 1'b0;
        end
      end else if (!digits_seen_r) begin
        // Between tokens: skip whitespace, open comments, start a token.
        out_valid_nxt = 1'b0;
        if (b == ppm_p6_pkg::CH_HASH) begin
          in_comment_nxt = 1'b1;
        end else if (!is_ws) begin
          digits_seen_nxt = 1'b1;
          if (phase_r == ppm_p6_pkg::PH_MAGIC) begin
            magic_nxt = (b == ppm_p6_pkg::CH_P) && (magic_r == ppm_p6_pkg::MG_NONE) ?
                        ppm_p6_pkg::MG_SAW_P : ppm_p6_pkg::MG_MISMATCH;
          end else begin
            acc_nxt = acc_fed;
          end
        end
      end else if (is_ws || b == ppm_p6_pkg::CH_HASH) begin
        // Token end.
        out_valid_nxt   = 1'b0;
        digits_seen_nxt = 1'b0;
        if (phase_r == ppm_p6_pkg::PH_MAGIC) begin
          if (magic_r == ppm_p6_pkg::MG_SAW_P6) begin
            phase_nxt = ppm_p6_pkg::PH_HEADER;
            field_nxt = ppm_p6_pkg::HF_WIDTH;
            acc_nxt   = '0;
          end else begin
            phase_nxt               = ppm_p6_pkg::PH_IDLE;
            out_valid_nxt           = 1'b1;
            out_data_nxt.kind       = ppm_p6_pkg::KIND_ERROR;
            out_data_nxt.error_code = ppm_p6_pkg::ERR_BAD_MAGIC;
          end
        end else if (!number_ok) begin
          phase_nxt               = ppm_p6_pkg::PH_IDLE;
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = ppm_p6_pkg::KIND_ERROR;
          out_data_nxt.error_code = ppm_p6_pkg::ERR_BAD_NUMBER;
        end else begin
          acc_nxt = '0;
          case (field_r)
            ppm_p6_pkg::HF_WIDTH: begin
              width_nxt = acc_r[DIM_W-1:0];
              field_nxt = ppm_p6_pkg::HF_HEIGHT;
            end
            ppm_p6_pkg::HF_HEIGHT: begin
              height_nxt = acc_r[DIM_W-1:0];
              field_nxt  = ppm_p6_pkg::HF_MAXVAL;
            end
            default: begin
              wide_nxt                  = (acc_r > ppm_p6_pkg::NARROW_MAXVAL);
              samples_left_nxt          = samples_total;
              byte_in_pair_nxt          = 1'b0;
              phase_nxt                 = ppm_p6_pkg::PH_PIXELS;
              out_valid_nxt             = 1'b1;
              out_data_nxt.kind         = ppm_p6_pkg::KIND_HEADER;
              out_data_nxt.image_width  = width_ext[14:0];
              out_data_nxt.image_height = height_ext[14:0];
              out_data_nxt.wide_samples = (acc_r > ppm_p6_pkg::NARROW_MAXVAL);
            end
          endcase
        end
      end else begin
        // Inside a token.
        out_valid_nxt = 1'b0;
        if (phase_r == ppm_p6_pkg::PH_MAGIC) begin
          magic_nxt = (b == ppm_p6_pkg::CH_6) && (magic_r == ppm_p6_pkg::MG_SAW_P) ?
                      ppm_p6_pkg::MG_SAW_P6 : ppm_p6_pkg::MG_MISMATCH;
        end else begin
          acc_nxt = acc_fed;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ppm_p6_pkg::PH_MAGIC;
      magic_r        <= ppm_p6_pkg::MG_NONE;
      field_r        <= ppm_p6_pkg::HF_WIDTH;
      in_comment_r   <= 1'b0;
      acc_r          <= '0;
      digits_seen_r  <= 1'b0;
      width_r        <= '0;
      height_r       <= '0;
      wide_r         <= 1'b0;
      samples_left_r <= '0;
      byte_in_pair_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      magic_r        <= magic_nxt;
      field_r        <= field_nxt;
      in_comment_r   <= in_comment_nxt;
      acc_r          <= acc_nxt;
      digits_seen_r  <= digits_seen_nxt;
      width_r        <= width_nxt;
      height_r       <= height_nxt;
      wide_r         <= wide_nxt;
      samples_left_r <= samples_left_nxt;
      byte_in_pair_r <= byte_in_pair_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers: result and the image size product.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    prod_r     <= PROD_W'(width_r) * PROD_W'(height_r);
  end

  // A byte taken while idle produces no result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.end_of_file && phase_r == ppm_p6_pkg::PH_IDLE |=> !out_valid_r)
    else $error("result produced while idle");

  // The last flag only marks pixel samples.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last |-> out_data_r.kind == ppm_p6_pkg::KIND_PIXEL)
    else $error("last flag on a non-pixel result");

  // Pixel phase awaiting a new sample always has samples left.
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ppm_p6_pkg::PH_PIXELS && !byte_in_pair_r |-> samples_left_r != '0)
    else $error("pixel phase with no samples left");

  // A header result always carries nonzero dimensions.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_nxt == ppm_p6_pkg::PH_PIXELS && phase_r == ppm_p6_pkg::PH_HEADER
    |-> width_r != '0 && height_r != '0)
    else $error("header accepted with zero dimension");

endmodule

// ----- test/ppm_p6_stream_parser_tb.sv -----
// Self-checking testbench for the P6 stream parser: random PPM files against a byte-level predictor.
module ppm_p6_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM_LIMIT    = 16384;
  localparam int unsigned BYTE_TARGET  = 930;
  localparam int unsigned STALL_AT     = 40;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  ppm_p6_pkg::in_req_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ppm_p6_pkg::out_req_t out_data;

  ppm_p6_stream_parser #(.MAX_DIM(DIM_LIMIT)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Stimulus, expectations and bookkeeping.
  ppm_p6_pkg::in_req_t  stream_q[$];
  logic [7:0]           file_q[$];
  ppm_p6_pkg::out_req_t pending_results[$];
  int unsigned errors = 0;
  int unsigned fed = 0;
  int unsigned files = 0;
  int unsigned results_seen = 0;
  int unsigned headers_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b1;

  // Tracked parser state.
  ppm_p6_pkg::phase_t          trk_phase;
  logic                        trk_comment;
  ppm_p6_pkg::magic_t          trk_magic;
  ppm_p6_pkg::field_t          trk_field;
  logic [ppm_p6_pkg::ACC_W-1:0] trk_acc;
  logic                        trk_token;
  logic [ppm_p6_pkg::ACC_W-1:0] trk_width;
  logic [ppm_p6_pkg::ACC_W-1:0] trk_height;
  logic                        trk_wide;
  logic [33:0]                 trk_left;
  logic                        trk_second;

  function automatic void clear_tracker();
    trk_phase   = ppm_p6_pkg::PH_MAGIC;
    trk_comment = 1'b0;
    trk_magic   = ppm_p6_pkg::MG_NONE;
    trk_field   = ppm_p6_pkg::HF_WIDTH;
    trk_acc     = '0;
    trk_token   = 1'b0;
    trk_width   = '0;
    trk_height  = '0;
    trk_wide    = 1'b0;
    trk_left    = '0;
    trk_second  = 1'b0;
  endfunction

  function automatic bit is_space(input logic [7:0] b);
    return b == ppm_p6_pkg::CH_SP || (b >= ppm_p6_pkg::CH_TAB && b <= ppm_p6_pkg::CH_CR);
  endfunction

  function automatic ppm_p6_pkg::out_req_t error_result(input logic [1:0] code);
    ppm_p6_pkg::out_req_t r;
    r = '0;
    r.kind = ppm_p6_pkg::KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic bit value_fits();
    int unsigned lim;
    lim = (trk_field == ppm_p6_pkg::HF_MAXVAL) ? ppm_p6_pkg::MAXVAL_LIMIT : DIM_LIMIT;
    return (trk_acc != 0) && (trk_acc <= lim);
  endfunction

  // Adds one byte to the token in progress: magic letters or decimal digits.
  function automatic void absorb_char(input logic [7:0] b);
    int unsigned v;
    if (trk_phase == ppm_p6_pkg::PH_MAGIC) begin
      if (trk_magic == ppm_p6_pkg::MG_NONE && b == ppm_p6_pkg::CH_P)
        trk_magic = ppm_p6_pkg::MG_SAW_P;
      else if (trk_magic == ppm_p6_pkg::MG_SAW_P && b == ppm_p6_pkg::CH_6)
        trk_magic = ppm_p6_pkg::MG_SAW_P6;
      else trk_magic = ppm_p6_pkg::MG_MISMATCH;
    end else if (b >= ppm_p6_pkg::CH_0 && b <= ppm_p6_pkg::CH_9) begin
      if (trk_acc < ppm_p6_pkg::ACC_SAT) begin
        v = trk_acc * 10 + (b - ppm_p6_pkg::CH_0);
        trk_acc = (v > ppm_p6_pkg::ACC_SAT) ? ppm_p6_pkg::ACC_SAT : v[ppm_p6_pkg::ACC_W-1:0];
      end
    end else begin
      trk_acc = ppm_p6_pkg::ACC_SAT;
    end
  endfunction

  // Advances the tracked parser by one request; returns 1 when a result is due.
  function automatic bit decode_byte(input ppm_p6_pkg::in_req_t rq,
                                     output ppm_p6_pkg::out_req_t res);
    logic [7:0] b;
    bit got;
    b = rq.data_byte;
    res = '0;
    got = 1'b0;
    if (rq.end_of_file) begin
      // End of file closes any open token and reports what was missing.
      case (trk_phase)
        ppm_p6_pkg::PH_MAGIC: begin
          got = 1'b1;
          res = error_result((trk_token && trk_magic != ppm_p6_pkg::MG_SAW_P6) ?
                             ppm_p6_pkg::ERR_BAD_MAGIC : ppm_p6_pkg::ERR_SHORT_HEADER);
        end
        ppm_p6_pkg::PH_HEADER: begin
          got = 1'b1;
          if (trk_token && !value_fits()) res = error_result(ppm_p6_pkg::ERR_BAD_NUMBER);
          else if (trk_token && trk_field == ppm_p6_pkg::HF_MAXVAL)
            res = error_result(ppm_p6_pkg::ERR_SHORT_PIXELS);
          else res = error_result(ppm_p6_pkg::ERR_SHORT_HEADER);
        end
        ppm_p6_pkg::PH_PIXELS: begin
          got = (trk_left != 0) || trk_second;
          if (got) res = error_result(ppm_p6_pkg::ERR_SHORT_PIXELS);
        end
        default: got = 1'b0;
      endcase
      clear_tracker();
      return got;
    end
    if (trk_phase == ppm_p6_pkg::PH_IDLE) return 1'b0;
    // Pixel data: wide samples pass only their first byte.
    if (trk_phase == ppm_p6_pkg::PH_PIXELS) begin
      if (trk_wide && trk_second) begin
        trk_second = 1'b0;
        if (trk_left == 0) trk_phase = ppm_p6_pkg::PH_IDLE;
        return 1'b0;
      end
      if (trk_left != 0) trk_left--;
      if (trk_wide) trk_second = 1'b1;
      else if (trk_left == 0) trk_phase = ppm_p6_pkg::PH_IDLE;
      res.kind = ppm_p6_pkg::KIND_PIXEL;
      res.sample = b;
      res.last = (trk_left == 0);
      return 1'b1;
    end
    if (trk_comment) begin
      if (b == ppm_p6_pkg::CH_LF) trk_comment = 1'b0;
      return 1'b0;
    end
    if (!trk_token) begin
      if (is_space(b)) return 1'b0;
      if (b == ppm_p6_pkg::CH_HASH) begin
        trk_comment = 1'b1;
        return 1'b0;
      end
      trk_token = 1'b1;
      absorb_char(b);
      return 1'b0;
    end
    if (!is_space(b) && b != ppm_p6_pkg::CH_HASH) begin
      absorb_char(b);
      return 1'b0;
    end
    // The token ends on this byte, which is consumed.
    trk_token = 1'b0;
    if (trk_phase == ppm_p6_pkg::PH_MAGIC) begin
      if (trk_magic == ppm_p6_pkg::MG_SAW_P6) begin
        trk_phase = ppm_p6_pkg::PH_HEADER;
        trk_field = ppm_p6_pkg::HF_WIDTH;
        trk_acc = '0;
        return 1'b0;
      end
      trk_phase = ppm_p6_pkg::PH_IDLE;
      res = error_result(ppm_p6_pkg::ERR_BAD_MAGIC);
      return 1'b1;
    end
    if (!value_fits()) begin
      trk_phase = ppm_p6_pkg::PH_IDLE;
      res = error_result(ppm_p6_pkg::ERR_BAD_NUMBER);
      return 1'b1;
    end
    case (trk_field)
      ppm_p6_pkg::HF_WIDTH: begin
        trk_width = trk_acc;
        trk_field = ppm_p6_pkg::HF_HEIGHT;
      end
      ppm_p6_pkg::HF_HEIGHT: begin
        trk_height = trk_acc;
        trk_field = ppm_p6_pkg::HF_MAXVAL;
      end
      default: begin
        trk_wide = trk_acc > ppm_p6_pkg::NARROW_MAXVAL;
        trk_left = trk_width * trk_height * 3;
        trk_second = 1'b0;
        trk_phase = ppm_p6_pkg::PH_PIXELS;
        res.kind = ppm_p6_pkg::KIND_HEADER;
        res.image_width = trk_width[14:0];
        res.image_height = trk_height[14:0];
        res.wide_samples = trk_wide;
        got = 1'b1;
      end
    endcase
    trk_acc = '0;
    return got;
  endfunction

  // Idle cycles before the next request; runs of no idling come from the quiet flag.
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // File generation helpers.
  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0: return ppm_p6_pkg::CH_TAB;
      1: return ppm_p6_pkg::CH_LF;
      2: return ppm_p6_pkg::CH_TAB + 8'd2;  // vertical tab
      3: return ppm_p6_pkg::CH_TAB + 8'd3;  // form feed
      4: return ppm_p6_pkg::CH_CR;
      default: return ppm_p6_pkg::CH_SP;
    endcase
  endfunction

  // A byte that is neither a digit, whitespace nor a comment mark.
  function automatic logic [7:0] pick_solid();
    return 8'($urandom_range(ppm_p6_pkg::CH_9 + 1, 8'hFF));
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 19))
      0: return DIM_LIMIT;
      1: return $urandom_range(1, DIM_LIMIT);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic int unsigned pick_maxval();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return 255;
      2: return 256;
      3: return ppm_p6_pkg::MAXVAL_LIMIT;
      4: return $urandom_range(1, 255);
      default: return $urandom_range(256, ppm_p6_pkg::MAXVAL_LIMIT);
    endcase
  endfunction

  // Appends one byte to the file being built.
  task automatic add_byte(input logic [7:0] c);
    file_q.insert(file_q.size(), c);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic put_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) s = {"00", s};
    put_text(s);
  endtask

  // Whitespace where a token may start, sometimes followed by a comment line.
  task automatic put_space();
    logic [7:0] c;
    add_byte(pick_space());
    if ($urandom_range(0, 2) == 0) begin
      add_byte(ppm_p6_pkg::CH_HASH);
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(0, 255));
        add_byte(c == ppm_p6_pkg::CH_LF ? ppm_p6_pkg::CH_SP : c);
      end
      add_byte(ppm_p6_pkg::CH_LF);
    end
  endtask

  // Token end (whitespace or a dropped '#'), then maybe more filler.
  task automatic put_sep();
    add_byte(($urandom_range(0, 4) == 0) ? ppm_p6_pkg::CH_HASH : pick_space());
    if ($urandom_range(0, 3) == 0) put_space();
  endtask

  task automatic put_garbage();
    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Moves the built file into the request stream and closes it with an end mark.
  task automatic send_file();
    ppm_p6_pkg::in_req_t rq;
    foreach (file_q[i]) begin
      rq.data_byte = file_q[i];
      rq.end_of_file = 1'b0;
      stream_q.insert(stream_q.size(), rq);
    end
    rq.data_byte = 8'($urandom_range(0, 255));
    rq.end_of_file = 1'b1;
    stream_q.insert(stream_q.size(), rq);
    fed += file_q.size() + 1;
    files++;
    file_q.delete();
  endtask

  // A well-formed image, sometimes cut short or followed by stray bytes.
  task automatic build_image();
    int unsigned w, h, mv, nbytes, hdr_len, full_len, keep;
    w = pick_dim();
    h = pick_dim();
    mv = pick_maxval();
    if ($urandom_range(0, 3) == 0) put_space();
    put_text("P6");
    put_sep();
    put_number(w);
    put_sep();
    put_number(h);
    put_sep();
    put_number(mv);
    add_byte(($urandom_range(0, 4) == 0) ? ppm_p6_pkg::CH_HASH : pick_space());
    hdr_len = file_q.size();
    nbytes = w * h * 3 * ((mv > 255) ? 2 : 1);
    // Huge images are only started; the end mark cuts them short.
    if (nbytes > 240) nbytes = $urandom_range(1, 60);
    repeat (nbytes) add_byte(8'($urandom_range(0, 255)));
    full_len = file_q.size();
    keep = full_len;
    if ($urandom_range(0, 9) == 0) keep = $urandom_range(0, hdr_len - 1);
    else if ($urandom_range(0, 5) == 0) keep = $urandom_range(hdr_len, full_len - 1);
    while (file_q.size() > keep) void'(file_q.pop_back());
    if (keep == full_len && $urandom_range(0, 3) == 0) put_garbage();
    send_file();
  endtask

  // Broken files: bad magic, bad numbers, early end of file, or plain noise.
  task automatic build_broken();
    int unsigned bad_field;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: put_text("P3");
          1: put_text("P");
          2: put_text("P66");
          3: put_text("p6");
          default: repeat ($urandom_range(1, 3)) add_byte(pick_solid());
        endcase
        if ($urandom_range(0, 1) == 0) begin
          put_sep();
          put_garbage();
        end
      end
      1: begin
        bad_field = $urandom_range(0, 2);
        put_text("P6");
        put_sep();
        for (int f = 0; f < bad_field; f++) begin
          put_number($urandom_range(1, DIM_LIMIT));
          put_sep();
        end
        case ($urandom_range(0, 4))
          0: put_text("0");
          1: put_text("000");
          2: put_number((bad_field == 2) ? ppm_p6_pkg::MAXVAL_LIMIT + 1 : DIM_LIMIT + 1);
          3: put_text("987654321012");
          default: begin
            put_number($urandom_range(1, 9));
            add_byte(pick_solid());
            put_number($urandom_range(0, 9));
          end
        endcase
        if ($urandom_range(0, 2) != 0) begin
          put_sep();
          put_garbage();
        end
      end
      2: repeat ($urandom_range(0, 12)) add_byte(8'($urandom_range(0, 255)));
      default: begin
        put_text("P6");
        if ($urandom_range(0, 1) == 0) begin
          put_sep();
          put_number($urandom_range(1, 3));
          put_sep();
          put_number($urandom_range(1, 3));
          put_sep();
          put_number(pick_maxval());
        end
      end
    endcase
    send_file();
  endtask

  // Sender: presents queued requests and updates the tracker on each acceptance.
  always @(posedge clk) begin : tx_side
    ppm_p6_pkg::out_req_t res;
    logic                 nxt_valid;
    ppm_p6_pkg::in_req_t  nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, res)) pending_results.insert(pending_results.size(), res);
        nxt_valid = 1'b0;
        in_gap = draw_wait(tx_quiet);
      end
      if (!nxt_valid) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (stream_q.size() != 0) begin
          nxt_data = stream_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      in_data <= nxt_data;
    end
  end

  task automatic flag_field(input string what, input logic [14:0] want_v,
                            input logic [14:0] got_v);
    $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
    errors++;
  endtask

  // Receiver: checks each accepted result and stalls at random, once for a long stretch.
  always @(posedge clk) begin : rx_side
    ppm_p6_pkg::out_req_t want;
    ppm_p6_pkg::out_req_t got;
    logic                 nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      nxt_ready = out_ready;
      if (out_valid && out_ready) begin
        got = out_data;
        results_seen++;
        if (got.kind == ppm_p6_pkg::KIND_HEADER) headers_seen++;
        if (got.kind == ppm_p6_pkg::KIND_ERROR) faults_seen++;
        if (pending_results.size() == 0) begin
          $display("[%0t] unexpected result: expected none, got %h", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind) flag_field("kind", 15'(want.kind), 15'(got.kind));
          if (got.sample !== want.sample)
            flag_field("sample", 15'(want.sample), 15'(got.sample));
          if (got.last !== want.last) flag_field("last", 15'(want.last), 15'(got.last));
          if (got.image_width !== want.image_width)
            flag_field("image_width", want.image_width, got.image_width);
          if (got.image_height !== want.image_height)
            flag_field("image_height", want.image_height, got.image_height);
          if (got.wide_samples !== want.wide_samples)
            flag_field("wide_samples", 15'(want.wide_samples), 15'(got.wide_samples));
          if (got.error_code !== want.error_code)
            flag_field("error_code", 15'(want.error_code), 15'(got.error_code));
        end
        out_gap = draw_wait(rx_quiet);
        if (results_seen == STALL_AT) out_gap = STALL_CYCLES;
        if (out_gap != 0) nxt_ready = 1'b0;
      end else if (!out_ready) begin
        if (out_gap != 0) out_gap--;
        if (out_gap == 0) nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // Run watchdog.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Builds the stimulus, releases reset and waits for the stream to drain.
  initial begin
    clear_tracker();

    // Directed files: empty file; comments, a '#' ending a token, wide samples and a stray
    // byte after the complete image; a wrong magic token cut by end of file.
    send_file();
    put_text("P6 #c\n1#1 65535 ");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(8'h01);
    add_byte(8'h5A);
    send_file();
    put_text("P7");
    send_file();

    // Mostly well-formed images, the rest broken files and noise.
    while (fed < BYTE_TARGET) begin
      if ($urandom_range(0, 9) < 7) build_image();
      else build_broken();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0 || in_valid || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("[%0t] %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("Streamed %0d requests in %0d files; checked %0d results (%0d headers, %0d errors).",
             fed, files, results_seen, headers_seen, faults_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
